FILE: design/tsm_pkg.sv
// Shared types, constants and conversion helpers for the two-way sorted merge unit.
package tsm_pkg;

    localparam int FIFO_DEPTH = 32;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CMP
    } state_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
        logic rd;
    } fifo_ctrl_t;

    // Sign-extend or truncate a 32-bit input value to the storage width.
    function automatic data_t to_data(input logic [31:0] v);
        logic signed [63:0] wide;
        begin
            wide = 64'(signed'(v));
            return wide[DATA_WIDTH-1:0];
        end
    endfunction

    // Sign-extend a stored value and take the low 32 bits.
    function automatic logic [31:0] to_out(input data_t d);
        logic signed [63:0] wide;
        begin
            wide = 64'(d);
            return wide[31:0];
        end
    endfunction

endpackage

FILE: design/tsm_fifo.sv
// One element FIFO of the merge unit: storage, pointers, fill count and registered head.
module tsm_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  tsm_pkg::fifo_ctrl_t ctrl,
    input  tsm_pkg::data_t     push_data,
    output tsm_pkg::data_t     head,
    output logic [tsm_pkg::CNT_W-1:0] count
);
    import tsm_pkg::*;

    data_t            mem [FIFO_DEPTH];
    data_t            head_reg;
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (ctrl.clear)
        begin
            wptr_next  = '0;
            rptr_next  = '0;
            count_next = '0;
        end
        else
        begin
            if (ctrl.push)
            begin
                wptr_next  = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + PTR_W'(1);
                count_next = count_next + CNT_W'(1);
            end
            if (ctrl.pop)
            begin
                rptr_next  = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + PTR_W'(1);
                count_next = count_next - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wptr_reg] <= push_data;
        end
        if (ctrl.rd)
        begin
            head_reg <= mem[rptr_reg];
        end
    end

    assign head  = head_reg;
    assign count = count_reg;

endmodule

FILE: design/two_way_sorted_merge_unit.sv
// Top level of the two-way sorted merge unit: input handling, merge sequencer, output register.
//
// Merges two ascending signed sequences into one. Each input item carries an element (or
// just an end marker) for sequence 0 or 1, chosen by tuser[0]; tlast ends that sequence.
// Elements wait in one FIFO_DEPTH-deep FIFO per sequence. After every input item the
// sequencer emits the smaller FIFO head while both FIFOs hold data (a tie sends the head of
// sequence 1 first), and once one sequence has ended it drains the other. A push into a
// full FIFO is dropped and every result of that item carries overflow; an element for a
// sequence that already ended is ignored silently. An item that emits nothing but drops
// an element or completes the merge gives one status result with value_valid low. When
// both sequences have ended and drained, the last result carries merge_done and the unit
// clears itself for the next pair. Once the input is taken, s_axis_tready stays low until
// the run for that item is finished. Each emitted element first has both FIFO heads read
// in ST_EVAL, then is compared and popped in the shared comparator in ST_CMP, which waits
// while the output register is stalled; an item with nothing to emit ends in ST_EVAL.
module two_way_sorted_merge_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] value
    input  logic [1:0]  s_axis_tuser,  // [0] list_select, [1] has_value
    input  logic        s_axis_tlast,  // end_of_list
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] merged_value
    output logic [3:0]  m_axis_tuser,  // [0] from_list, [1] value_valid, [2] merge_done,
                                       // [3] overflow
    output logic        m_axis_tlast   // last_of_run
);
    import tsm_pkg::*;

    state_t state_reg, state_next;

    logic [1:0] ended_reg, ended_next;
    logic       ovf_reg, ovf_next;

    // Output register
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [3:0]  out_user_reg;
    logic        out_last_reg;

    fifo_ctrl_t       ctrl0, ctrl1;
    data_t            head0, head1;
    logic [CNT_W-1:0] cnt0, cnt1;
    data_t            in_data;

    // Input decode
    logic in_accept;
    logic in_sel;
    logic in_has;
    logic in_full;

    // Sequencer decisions
    logic             can_emit;
    logic             src;
    logic [CNT_W-1:0] cnt0_after, cnt1_after;
    logic             more;
    logic             run_done;
    logic             slot_free;
    logic             load_out;
    logic [31:0]      load_data;
    logic [3:0]       load_user;
    logic             load_last;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_sel    = s_axis_tuser[0];
    assign in_has    = s_axis_tuser[1];
    assign in_full   = in_sel ? (cnt1 == CNT_FULL) : (cnt0 == CNT_FULL);
    assign in_data   = to_data(s_axis_tdata);

    assign slot_free = !out_valid_reg || m_axis_tready;

    // Another element can leave while both heads are present, or one holds data and the other side ended.
    assign can_emit = ((cnt0 != '0) && (cnt1 != '0))
                   || ((cnt0 != '0) && ended_reg[1])
                   || ((cnt1 != '0) && ended_reg[0]);

    // Shared comparator: pick the smaller head; on a tie take sequence 1.
    always_comb
    begin
        if ((cnt0 != '0) && (cnt1 != '0))
        begin
            src = (head0 < head1) ? 1'b0 : 1'b1;
        end
        else
        begin
            src = (cnt0 != '0) ? 1'b0 : 1'b1;
        end
    end

    assign cnt0_after = cnt0 - CNT_W'(!src);
    assign cnt1_after = cnt1 - CNT_W'(src);

    assign more = ((cnt0_after != '0) && (cnt1_after != '0))
               || ((cnt0_after != '0) && ended_reg[1])
               || ((cnt1_after != '0) && ended_reg[0]);

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ended_next = ended_reg;
        ovf_next   = ovf_reg;
        ctrl0      = '0;
        ctrl1      = '0;
        run_done   = 1'b0;
        load_out   = 1'b0;
        load_data  = '0;
        load_user  = '0;
        load_last  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    ovf_next = 1'b0;
                    if (in_has && !ended_reg[in_sel])
                    begin
                        if (in_full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else if (in_sel)
                        begin
                            ctrl1.push = 1'b1;
                        end
                        else
                        begin
                            ctrl0.push = 1'b1;
                        end
                    end
                    if (s_axis_tlast)
                    begin
                        ended_next[in_sel] = 1'b1;
                    end
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                if (can_emit)
                begin
                    // Fetch both heads for the comparator.
                    ctrl0.rd   = 1'b1;
                    ctrl1.rd   = 1'b1;
                    state_next = ST_CMP;
                end
                else
                begin
                    // Nothing to emit at the start of a run: status result or quiet.
                    run_done = ended_reg[0] && ended_reg[1] && (cnt0 == '0) && (cnt1 == '0);
                    if (ovf_reg || run_done)
                    begin
                        if (slot_free)
                        begin
                            load_out   = 1'b1;
                            load_user  = {ovf_reg, run_done, 1'b0, 1'b0};
                            load_last  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                    if (run_done && state_next == ST_IDLE)
                    begin
                        ctrl0.clear = 1'b1;
                        ctrl1.clear = 1'b1;
                        ended_next  = '0;
                    end
                end
            end

            ST_CMP:
            begin
                if (slot_free)
                begin
                    run_done  = !more && ended_reg[0] && ended_reg[1]
                             && (cnt0_after == '0) && (cnt1_after == '0);
                    load_out  = 1'b1;
                    load_data = to_out(src ? head1 : head0);
                    load_user = {ovf_reg, run_done, 1'b1, src};
                    load_last = !more;
                    if (src)
                    begin
                        ctrl1.pop = 1'b1;
                    end
                    else
                    begin
                        ctrl0.pop = 1'b1;
                    end
                    if (run_done)
                    begin
                        ctrl0.clear = 1'b1;
                        ctrl1.clear = 1'b1;
                        ended_next  = '0;
                    end
                    state_next = more ? ST_EVAL : ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ended_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ended_reg <= ended_next;
            ovf_reg   <= ovf_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the payload until taken; load only into a free slot.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= load_data;
            out_user_reg <= load_user;
            out_last_reg <= load_last;
        end
    end

    tsm_fifo u_fifo0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl0),
        .push_data (in_data),
        .head      (head0),
        .count     (cnt0)
    );

    tsm_fifo u_fifo1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl1),
        .push_data (in_data),
        .head      (head1),
        .count     (cnt1)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: design/tsm_checker.sv
// Port-level assertions for the two-way sorted merge unit and their bind.
module tsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // An accepted item blocks the input for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    // A status-only result ends its run, flags something and carries no element.
    a_status_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |->
            m_axis_tlast && (m_axis_tuser[2] || m_axis_tuser[3])
            && m_axis_tdata == 32'd0 && !m_axis_tuser[0])
        else $error("malformed status-only result");

    // Merge completion appears only on the last result of a run.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast)
        else $error("merge_done on a result that is not last");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind two_way_sorted_merge_unit tsm_checker u_tsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: bench/merge_check_pkg.sv
`timescale 1ns / 1ps
// Merge predictor and result scoreboard for the two-way sorted merge unit testbench.
package merge_check_pkg;

    import tsm_pkg::*;

    localparam bit LIST_FIRST   = 1'b0;
    localparam bit LIST_SECOND  = 1'b1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [31:0] merged_value;
        logic        from_list;
        logic        value_valid;
        logic        last_of_run;
        logic        merge_done;
        logic        overflow;
    } merge_result_t;

    function automatic string describe(merge_result_t r);
        return $sformatf("value=%0d from=%0b valid=%0b last=%0b done=%0b ovf=%0b",
                         $signed(r.merged_value), r.from_list, r.value_valid,
                         r.last_of_run, r.merge_done, r.overflow);
    endfunction

    class merge_scoreboard;
        data_t         first_held[$];
        data_t         second_held[$];
        bit [1:0]      list_ended;
        merge_result_t expected_results[$];
        int            failures;
        int            results_seen;
        int            merges_done;
        int            overflow_results;

        // Predict the results of one accepted item; return 1 if the item did anything.
        function bit note_input(bit which, logic [31:0] value, bit has, bit eol);
            merge_result_t run[$];
            merge_result_t r;
            data_t         elem;
            bit            dropped;
            bit            done;
            bit            take;
            bit            active;
            dropped = 1'b0;
            done    = 1'b0;
            active  = (has || eol) && !list_ended[which];
            elem    = data_t'(signed'(value));
            if (has && !list_ended[which]) begin
                if (which == LIST_SECOND) begin
                    if (second_held.size() >= FIFO_DEPTH)
                        dropped = 1'b1;
                    else
                        second_held.push_back(elem);
                end
                else begin
                    if (first_held.size() >= FIFO_DEPTH)
                        dropped = 1'b1;
                    else
                        first_held.push_back(elem);
                end
            end
            if (eol)
                list_ended[which] = 1'b1;

            // Emit the smaller head while both are present; drain once the other has ended.
            forever begin
                if (first_held.size() > 0 && second_held.size() > 0)
                    take = (first_held[0] < second_held[0]) ? LIST_FIRST : LIST_SECOND;
                else if (first_held.size() > 0 && list_ended[LIST_SECOND])
                    take = LIST_FIRST;
                else if (second_held.size() > 0 && list_ended[LIST_FIRST])
                    take = LIST_SECOND;
                else
                    break;
                r = '0;
                r.value_valid = 1'b1;
                r.from_list   = take;
                if (take == LIST_SECOND)
                    r.merged_value = 32'(second_held.pop_front());
                else
                    r.merged_value = 32'(first_held.pop_front());
                run.push_back(r);
            end

            if (list_ended == 2'b11 && first_held.size() == 0 && second_held.size() == 0) begin
                done       = 1'b1;
                list_ended = 2'b00;
            end
            if (run.size() == 0 && (dropped || done)) begin
                r = '0;
                run.push_back(r);
            end
            foreach (run[k])
                run[k].overflow = dropped;
            if (run.size() > 0) begin
                run[run.size()-1].last_of_run = 1'b1;
                run[run.size()-1].merge_done  = done;
            end
            foreach (run[k])
                expected_results.push_back(run[k]);
            return active;
        endfunction

        // Compare one accepted result against the oldest expectation.
        function void check_result(logic [31:0] tdata, logic [3:0] tuser, logic tlast);
            merge_result_t seen;
            merge_result_t want;
            seen.merged_value = tdata;
            seen.from_list    = tuser[0];
            seen.value_valid  = tuser[1];
            seen.merge_done   = tuser[2];
            seen.overflow     = tuser[3];
            seen.last_of_run  = tlast;
            results_seen++;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("Result with nothing expected: %s", describe(seen));
                return;
            end
            want = expected_results.pop_front();
            if (want.merge_done)
                merges_done++;
            if (want.overflow)
                overflow_results++;
            if (seen !== want) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("Result %0d differs", results_seen);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(seen));
                end
            end
        endfunction
    endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the two-way sorted merge unit: stimulus, output stalls and final verdict.
module tb_top;

    import tsm_pkg::*;
    import merge_check_pkg::*;

    // One input item as it travels on the slave side.
    typedef struct packed {
        logic        which;
        logic [31:0] value;
        logic        has;
        logic        eol;
    } merge_item_t;

    localparam int RANDOM_ITEMS = 320;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] value
    logic [1:0]  s_axis_tuser = '0;   // [0] list_select, [1] has_value
    logic        s_axis_tlast = 1'b0; // end_of_list
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] merged_value
    logic [3:0]  m_axis_tuser;        // [0] from_list, [1] value_valid, [2] merge_done,
                                      // [3] overflow
    logic        m_axis_tlast;        // last_of_run

    merge_scoreboard sb = new();

    int items_sent;
    int active_items;
    int burst_left;

    two_way_sorted_merge_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run, even with every item at its longest.
    initial
    begin
        #4000000;
        $display("Timeout: %0d results still expected", sb.expected_results.size());
        $display("two_way_sorted_merge_unit: mismatch");
        $finish;
    end

    // Check every result at the edge where it is accepted; the values read here are the
    // ones the block presented before the edge.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Receiver: switch between stall styles in spans of random length, so that stalls
    // land on every phase of a drain run, with some spans always ready.
    initial
    begin
        int style;
        int span;
        int tick;
        tick = 0;
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(16, 96);
            repeat (span)
            begin
                @(posedge clk);
                tick++;
                case (style)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 5) != 0);
                    default: m_axis_tready <= ((tick % 9) >= 5);
                endcase
            end
        end
    end

    // Drive one item and hold it until the block takes it, then predict its results.
    // Valid stays high into the next item unless the burst ends here with a gap.
    task automatic send_item(bit which, logic [31:0] value, bit has, bit eol);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= {has, which};
        s_axis_tlast  <= eol;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        items_sent++;
        if (sb.note_input(which, value, has, eol))
            active_items++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Hold the sender until every expected result has come back.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_results.size() != 0);
    endtask

    // Pick an element value: full range, a narrow band that forces ties, or extremes.
    function automatic int draw_value(int style);
        case (style)
            2: return $urandom_range(0, 8) - 4;
            3:
                case ($urandom_range(0, 5))
                    0:       return $signed(32'h8000_0000);
                    1:       return $signed(32'h7fff_ffff);
                    2:       return 0;
                    3:       return -1;
                    4:       return 1;
                    default: return $urandom;
                endcase
            default: return $urandom;
        endcase
    endfunction

    // Build one sequence: ascending unless broken, closed either by tlast on the last
    // element or by a separate end marker.
    task automatic build_list(bit which, int len, int style, bit broken,
                              ref merge_item_t list[$]);
        int vals[$];
        int v;
        int pos;
        repeat (len)
        begin
            v = draw_value(style);
            if (broken) begin
                vals.push_back(v);
            end
            else begin
                pos = 0;
                while (pos < vals.size() && vals[pos] <= v)
                    pos++;
                vals.insert(pos, v);
            end
        end
        foreach (vals[k])
            list.push_back('{which: which, value: vals[k], has: 1'b1, eol: 1'b0});
        if (len > 0 && $urandom_range(0, 1) == 1)
            list[list.size()-1].eol = 1'b1;
        else
            list.push_back('{which: which, value: $urandom, has: 1'b0, eol: 1'b1});
    endtask

    // Run one full merge of two sequences. A flood pair sends one sequence whole, past
    // the FIFO depth, before anything of the other, so the surplus gets dropped.
    task automatic run_pair(bit flood);
        merge_item_t list_a[$];
        merge_item_t list_b[$];
        merge_item_t pick;
        int          style;
        int          len_a;
        int          len_b;
        bit          broken;
        bit          side_a;
        bit          from_a;
        bit [1:0]    pair_ended;
        style  = $urandom_range(0, 3);
        broken = ($urandom_range(0, 9) == 0);
        side_a = 1'($urandom_range(0, 1));
        if (flood) begin
            len_a = $urandom_range(FIFO_DEPTH + 1, FIFO_DEPTH + 6);
            len_b = $urandom_range(0, 3);
        end
        else begin
            len_a = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 10);
            len_b = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 10);
        end
        build_list(side_a, len_a, style, broken, list_a);
        build_list(!side_a, len_b, style, broken, list_b);
        pair_ended = 2'b00;
        while (list_a.size() + list_b.size() > 0)
        begin
            if (list_b.size() == 0)
                from_a = 1'b1;
            else if (list_a.size() == 0)
                from_a = 1'b0;
            else
                from_a = flood ? 1'b1 : 1'($urandom_range(0, 1));
            if (from_a)
                pick = list_a.pop_front();
            else
                pick = list_b.pop_front();
            // Sprinkle noise: an element for a sequence that already ended, or an
            // item that carries neither an element nor an end marker.
            if ($urandom_range(0, 11) == 0) begin
                if (pair_ended == 2'b01 || pair_ended == 2'b10)
                    send_item(pair_ended[LIST_SECOND] ? LIST_SECOND : LIST_FIRST,
                              $urandom, 1'b1, 1'($urandom_range(0, 1)));
                else
                    send_item(1'($urandom_range(0, 1)), $urandom, 1'b0, 1'b0);
            end
            send_item(pick.which, pick.value, pick.has, pick.eol);
            if (pick.eol)
                pair_ended[pick.which] = 1'b1;
        end
    endtask

    initial
    begin
        int target;
        items_sent   = 0;
        active_items = 0;
        burst_left   = $urandom_range(1, 12);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tie at the most negative value: the head of the second sequence leaves first.
        send_item(LIST_FIRST,  32'h8000_0000, 1'b1, 1'b0);
        send_item(LIST_SECOND, 32'h8000_0000, 1'b1, 1'b0);
        send_item(LIST_SECOND, 32'h7fff_ffff, 1'b1, 1'b0);
        // End the first sequence on an element, which also drains the second.
        send_item(LIST_FIRST,  32'd5,         1'b1, 1'b1);
        // Bare end marker completes the merge with a status-only result.
        send_item(LIST_SECOND, 32'd0,         1'b0, 1'b1);
        // Element after end is ignored; a tie then sends the head of the second sequence first.
        send_item(LIST_FIRST,  32'hffff_ffff, 1'b1, 1'b1);
        send_item(LIST_FIRST,  32'd7,         1'b1, 1'b0);
        send_item(LIST_SECOND, 32'hffff_ffff, 1'b1, 1'b0);
        send_item(LIST_SECOND, 32'd0,         1'b0, 1'b0);
        send_item(LIST_SECOND, 32'h7fff_ffff, 1'b1, 1'b1);
        // Both sequences empty: done arrives on its own.
        send_item(LIST_SECOND, 32'd0,         1'b0, 1'b1);
        send_item(LIST_FIRST,  32'd0,         1'b0, 1'b1);
        // Alternating bit patterns, a negative head and a tie with drain.
        send_item(LIST_FIRST,  32'h5555_5555, 1'b1, 1'b0);
        send_item(LIST_SECOND, 32'haaaa_aaaa, 1'b1, 1'b0);
        send_item(LIST_SECOND, 32'h5555_5555, 1'b1, 1'b1);
        send_item(LIST_FIRST,  32'h7fff_ffff, 1'b1, 1'b1);

        hold_until_drained();

        // Random merges; the first one floods a FIFO so overflow is always reached.
        target = active_items + RANDOM_ITEMS;
        run_pair(1'b1);
        while (active_items < target)
        begin
            run_pair($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 5) == 0)
                hold_until_drained();
        end

        // Wait out the last results, then a margin for anything unexpected.
        hold_until_drained();
        repeat (40) @(posedge clk);

        $display("Covered %0d items (%0d with effect) and %0d results,", items_sent,
                 active_items, sb.results_seen);
        $display("including %0d completed merges and %0d overflow results.",
                 sb.merges_done, sb.overflow_results);
        if (sb.failures == 0)
            $display("two_way_sorted_merge_unit: match");
        else
            $display("two_way_sorted_merge_unit: mismatch");
        $finish;
    end

endmodule
